// ===== hw/rtl/dcac_rlc_pkg.sv =====
`default_nettype none

package dcac_rlc_pkg;

	localparam logic [7:0] SYM_EOB = 8'h00;
	localparam logic [7:0] SYM_ZRL = 8'hF0;
	localparam logic [12:0] MAX_MAG = 13'd2047;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [3:0] SIZE_MAX = 4'd11;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic signed [11:0] coefficient;
		logic [1:0] component;
	} in_word_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic [10:0] amplitude_bits;
		logic [3:0] size_category;
		logic is_dc;
		logic [1:0] symbol_component;
		logic range_error;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic is_dc;
		logic is_eob;
		logic signed [12:0] value;
		logic [1:0] nzrl;
		logic [3:0] run;
		logic [1:0] comp;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dcac_rlc_front.sv =====
`default_nettype none

module dcac_rlc_front #(
	parameter int NUM_COMPONENTS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  coef_valid,
	output logic                       coef_ready,
	input  wire dcac_rlc_pkg::in_word_t coef_word,
	input  wire dcac_rlc_pkg::q_status_t q_status,
	output logic                       push,
	output dcac_rlc_pkg::cmd_t         push_cmd
);

	localparam int CW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
	localparam logic [1:0] COMP_TOP = 2'(NUM_COMPONENTS - 1);

	logic signed [11:0] prev_dc_q [NUM_COMPONENTS];
	logic [5:0] pos_q;
	logic [5:0] run_q;
	logic [1:0] bcomp_q;

	logic accept;
	logic at_dc;
	logic coef_zero;
	logic [1:0] comp_clamp;
	logic [CW-1:0] comp_idx;
	logic signed [11:0] prev_sel;
	logic signed [12:0] diff;

	assign coef_ready = !q_status.full;
	assign accept = coef_valid && coef_ready;
	assign at_dc = (pos_q == 6'd0);
	assign coef_zero = (coef_word.coefficient == 12'sd0);
	assign comp_clamp = (coef_word.component > COMP_TOP) ? COMP_TOP : coef_word.component;
	assign comp_idx = comp_clamp[CW-1:0];
	assign prev_sel = prev_dc_q[comp_idx];
	assign diff = 13'(coef_word.coefficient) - 13'(prev_sel);

	always_comb begin
		push_cmd.is_dc = at_dc;
		push_cmd.is_eob = !at_dc && coef_zero;
		push_cmd.value = at_dc ? diff : 13'(coef_word.coefficient);
		push_cmd.nzrl = (at_dc || coef_zero) ? 2'd0 : run_q[5:4];
		push_cmd.run = at_dc ? 4'd0 : run_q[3:0];
		push_cmd.comp = at_dc ? comp_clamp : bcomp_q;
		push = accept && (at_dc || !coef_zero || pos_q == dcac_rlc_pkg::LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 6'd0;
			run_q <= 6'd0;
			bcomp_q <= 2'd0;
			for (int i = 0; i < NUM_COMPONENTS; i++) begin
				prev_dc_q[i] <= 12'sd0;
			end
		end else if (accept) begin
			if (at_dc) begin
				prev_dc_q[comp_idx] <= coef_word.coefficient;
				bcomp_q <= comp_clamp;
				run_q <= 6'd0;
				pos_q <= 6'd1;
			end else if (pos_q == dcac_rlc_pkg::LAST_POS) begin
				pos_q <= 6'd0;
				run_q <= 6'd0;
			end else begin
				pos_q <= pos_q + 6'd1;
				run_q <= coef_zero ? run_q + 6'd1 : 6'd0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dcac_rlc_queue.sv =====
`default_nettype none

module dcac_rlc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire dcac_rlc_pkg::cmd_t push_cmd,
	input  wire logic               pop,
	output dcac_rlc_pkg::cmd_t      head_cmd,
	output dcac_rlc_pkg::q_status_t q_status
);

	localparam int PW = dcac_rlc_pkg::QPTR_W;
	localparam int DEPTH = dcac_rlc_pkg::QUEUE_DEPTH;

	dcac_rlc_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;

	assign q_status.full = (count_q == (PW+1)'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dcac_rlc_back.sv =====
`default_nettype none

module dcac_rlc_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dcac_rlc_pkg::cmd_t      head_cmd,
	input  wire dcac_rlc_pkg::q_status_t q_status,
	output logic                        pop,
	output logic                        sym_valid,
	input  wire logic                   sym_ready,
	output dcac_rlc_pkg::out_word_t     sym_word
);

	logic out_valid_q;
	dcac_rlc_pkg::out_word_t out_q;
	logic [1:0] zrl_cnt_q;

	logic load;
	logic emit_zrl;
	logic neg;
	logic [12:0] mag;
	logic err;
	logic [3:0] size;
	logic [11:0] mask;
	logic signed [12:0] amp_src;
	logic [10:0] amp;
	dcac_rlc_pkg::out_word_t next_word;

	assign load = !q_status.empty && (!out_valid_q || sym_ready);
	assign emit_zrl = (zrl_cnt_q != head_cmd.nzrl);
	assign pop = load && !emit_zrl;

	always_comb begin
		neg = head_cmd.value[12];
		mag = neg ? 13'(-head_cmd.value) : head_cmd.value;
		err = (mag > dcac_rlc_pkg::MAX_MAG);
		size = 4'd0;
		for (int i = 0; i < 11; i++) begin
			if (mag[i]) begin
				size = 4'(i + 1);
			end
		end
		if (err) begin
			size = dcac_rlc_pkg::SIZE_MAX;
		end
		mask = (12'h1 << size) - 12'h1;
		amp_src = neg ? head_cmd.value - 13'sd1 : head_cmd.value;
		amp = amp_src[10:0] & mask[10:0];
	end

	always_comb begin
		next_word.symbol_component = head_cmd.comp;
		next_word.is_dc = 1'b0;
		next_word.amplitude_bits = 11'd0;
		next_word.size_category = 4'd0;
		next_word.range_error = 1'b0;
		next_word.last = 1'b1;
		if (emit_zrl) begin
			next_word.symbol = dcac_rlc_pkg::SYM_ZRL;
			next_word.last = 1'b0;
		end else if (head_cmd.is_eob) begin
			next_word.symbol = dcac_rlc_pkg::SYM_EOB;
		end else begin
			next_word.is_dc = head_cmd.is_dc;
			next_word.symbol = head_cmd.is_dc ? {4'd0, size} : {head_cmd.run, size};
			next_word.amplitude_bits = amp;
			next_word.size_category = size;
			next_word.range_error = err;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			zrl_cnt_q <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				zrl_cnt_q <= emit_zrl ? zrl_cnt_q + 2'd1 : 2'd0;
			end else if (sym_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sym_valid = out_valid_q;
	assign sym_word = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dc_ac_run_length_coder_core.sv =====
// An accepted coefficient word that yields symbols is written into the command queue, then into the output register.
// Throughput: one coefficient word per cycle while the command queue is not full; a coefficient that needs ZRL
// symbols stays at the queue head while they leave the one-symbol-per-cycle output register, which stalls on sym_ready.
// Reset: arst_n clears the stored DC values, zero run, block position and the queue.
`default_nettype none

module dc_ac_run_length_coder_core #(
	parameter int NUM_COMPONENTS = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    coef_valid,
	output logic                         coef_ready,
	input  wire dcac_rlc_pkg::in_word_t  coef_word,
	output logic                         sym_valid,
	input  wire logic                    sym_ready,
	output dcac_rlc_pkg::out_word_t      sym_word
);

	logic push;
	logic pop;
	dcac_rlc_pkg::cmd_t push_cmd;
	dcac_rlc_pkg::cmd_t head_cmd;
	dcac_rlc_pkg::q_status_t q_status;

	dcac_rlc_front #(
		.NUM_COMPONENTS(NUM_COMPONENTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_valid(coef_valid),
		.coef_ready(coef_ready),
		.coef_word (coef_word),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	dcac_rlc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.q_status(q_status)
	);

	dcac_rlc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_status (q_status),
		.pop      (pop),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.sym_word (sym_word)
	);

	a_err_size: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_word.range_error |-> sym_word.size_category == dcac_rlc_pkg::SIZE_MAX)
		else $error("range error without maximum size");

	a_zrl_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && !sym_word.is_dc && sym_word.symbol == dcac_rlc_pkg::SYM_ZRL
		|-> !sym_word.last)
		else $error("ZRL marked as last symbol");

	a_dc_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_word.is_dc |-> sym_word.symbol == {4'd0, sym_word.size_category}
		&& sym_word.last)
		else $error("malformed DC symbol");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("push into full queue");

endmodule

`default_nettype wire

// ===== tb/dc_ac_run_length_coder_core_tb.sv =====
`default_nettype none

module dc_ac_run_length_coder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCOMP = 4;
	localparam int RUN_CHUNK = 16;
	localparam int MAX_ZRL = 3;
	localparam int BLOCK_LEN = 64;

	logic clk;
	logic arst_n;
	logic coef_valid;
	logic coef_ready;
	dcac_rlc_pkg::in_word_t coef_word;
	logic sym_valid;
	logic sym_ready;
	dcac_rlc_pkg::out_word_t sym_word;

	dcac_rlc_pkg::out_word_t expected_symbols[$];
	int prior_dc[NCOMP] = '{0, 0, 0, 0};
	int zero_count = 0;
	int coef_pos = 0;
	logic [1:0] blk_comp = '0;

	int mismatches = 0;
	bit src_idle = 1'b0;
	bit snk_idle = 1'b0;
	int hold_cycles = 0;
	int block_buf[BLOCK_LEN];

	dc_ac_run_length_coder_core #(
		.NUM_COMPONENTS(NCOMP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.coef_valid(coef_valid),
		.coef_ready(coef_ready),
		.coef_word(coef_word),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.sym_word(sym_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic dcac_rlc_pkg::out_word_t make_word(input logic [7:0] sym,
			input logic [10:0] amp, input logic [3:0] size, input logic dc,
			input logic [1:0] comp, input logic err);
		dcac_rlc_pkg::out_word_t w;
		w.symbol = sym;
		w.amplitude_bits = amp;
		w.size_category = size;
		w.is_dc = dc;
		w.symbol_component = comp;
		w.range_error = err;
		w.last = 1'b0;
		return w;
	endfunction

	task automatic size_and_bits(input int v, output logic [3:0] s, output logic [10:0] a,
			output logic e);
		int mag;
		int k;
		int mask;
		mag = (v < 0) ? -v : v;
		e = 1'b0;
		k = 0;
		if (mag > int'(dcac_rlc_pkg::MAX_MAG)) begin
			e = 1'b1;
			k = int'(dcac_rlc_pkg::SIZE_MAX);
		end else begin
			while (k < int'(dcac_rlc_pkg::SIZE_MAX) && (mag >> k) != 0) k++;
		end
		mask = (1 << k) - 1;
		a = 11'(((v < 0) ? v - 1 : v) & mask);
		s = 4'(k);
	endtask

	task automatic predict_symbols(input dcac_rlc_pkg::in_word_t w);
		dcac_rlc_pkg::out_word_t res[4];
		dcac_rlc_pkg::out_word_t r;
		int n;
		int c;
		int d;
		logic [1:0] comp;
		logic [3:0] s;
		logic [10:0] a;
		logic e;
		n = 0;
		c = $signed(w.coefficient);
		if (coef_pos == 0) begin
			comp = w.component;
			if (int'(comp) >= NCOMP) comp = 2'(NCOMP - 1);
			blk_comp = comp;
			d = c - prior_dc[comp];
			prior_dc[comp] = c;
			size_and_bits(d, s, a, e);
			res[n] = make_word({4'd0, s}, a, s, 1'b1, comp, e);
			n++;
			zero_count = 0;
			coef_pos = 1;
		end else begin
			if (c == 0) begin
				if (coef_pos == int'(dcac_rlc_pkg::LAST_POS)) begin
					res[n] = make_word(dcac_rlc_pkg::SYM_EOB, '0, '0, 1'b0, blk_comp, 1'b0);
					n++;
				end
				zero_count = (zero_count + 1) & 63;
			end else begin
				while (zero_count >= RUN_CHUNK && n < MAX_ZRL) begin
					res[n] = make_word(dcac_rlc_pkg::SYM_ZRL, '0, '0, 1'b0, blk_comp, 1'b0);
					n++;
					zero_count -= RUN_CHUNK;
				end
				size_and_bits(c, s, a, e);
				res[n] = make_word({zero_count[3:0], s}, a, s, 1'b0, blk_comp, e);
				n++;
				zero_count = 0;
			end
			if (coef_pos >= int'(dcac_rlc_pkg::LAST_POS)) begin
				coef_pos = 0;
				zero_count = 0;
			end else begin
				coef_pos++;
			end
		end
		for (int i = 0; i < n; i++) begin
			r = res[i];
			r.last = (i == n - 1);
			expected_symbols.insert(expected_symbols.size(), r);
		end
	endtask

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_symbol(input dcac_rlc_pkg::out_word_t got);
		dcac_rlc_pkg::out_word_t want;
		if (expected_symbols.size() == 0) begin
			$display("%0t: unexpected symbol word, expected none, actual %h", $time, got);
			mismatches++;
		end else begin
			want = expected_symbols.pop_front();
			compare_field("symbol", want.symbol, got.symbol);
			compare_field("amplitude_bits", want.amplitude_bits, got.amplitude_bits);
			compare_field("size_category", want.size_category, got.size_category);
			compare_field("is_dc", want.is_dc, got.is_dc);
			compare_field("symbol_component", want.symbol_component, got.symbol_component);
			compare_field("range_error", want.range_error, got.range_error);
			compare_field("last", want.last, got.last);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (coef_valid && coef_ready) predict_symbols(coef_word);
			if (sym_valid && sym_ready) check_symbol(sym_word);
		end
	end

	// The receiver takes a long hold when one is requested, else a random stall when snk_idle is set.
	initial begin
		int stall;
		sym_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = snk_idle ? $urandom_range(0, 11) : 0;
			end
			if (stall > 0) begin
				sym_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sym_ready <= 1'b1;
			do @(posedge clk); while (!sym_valid);
		end
	end

	task automatic send_coef(input int c, input logic [1:0] comp);
		dcac_rlc_pkg::in_word_t w;
		int gap;
		w.coefficient = 12'(c);
		w.component = comp;
		gap = src_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			coef_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coef_valid <= 1'b1;
		coef_word <= w;
		do @(posedge clk); while (!coef_ready);
	endtask

	task automatic send_block(input logic [1:0] comp);
		for (int i = 0; i < BLOCK_LEN; i++) begin
			send_coef(block_buf[i], (i == 0) ? comp : 2'($urandom_range(0, 3)));
		end
	endtask

	function automatic int rand_coef(input int zero_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct) return 0;
		r = $urandom_range(0, 9);
		if (r == 0) return 2047;
		if (r == 1) return -2048;
		if (r < 5) return int'($urandom_range(0, 15)) - 8;
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	task automatic fill_block(input int zero_pct, input bit nonzero_last);
		block_buf[0] = rand_coef(0);
		for (int i = 1; i < BLOCK_LEN; i++) block_buf[i] = rand_coef(zero_pct);
		if (nonzero_last) begin
			do block_buf[BLOCK_LEN - 1] = rand_coef(0); while (block_buf[BLOCK_LEN - 1] == 0);
		end
	endtask

	task automatic clear_block();
		for (int i = 0; i < BLOCK_LEN; i++) block_buf[i] = 0;
	endtask

	// Extreme values, range errors, runs of sixteen and seventeen zeros, and an EOB.
	task automatic test_extremes_and_eob();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		clear_block();
		block_buf[0] = 2047;
		block_buf[1] = 1;
		block_buf[2] = -1;
		block_buf[3] = 2047;
		block_buf[4] = -2048;
		block_buf[5] = -2047;
		block_buf[22] = 3;
		block_buf[40] = -5;
		send_block(2'd0);
	endtask

	// A DC difference beyond the range, then the longest run ahead of a nonzero last term.
	task automatic test_long_zero_run();
		src_idle = 1'b0;
		snk_idle = 1'b1;
		clear_block();
		block_buf[0] = -2048;
		block_buf[63] = 5;
		send_block(2'd0);
	endtask

	task automatic test_random_blocks();
		int style;
		for (int b = 0; b < 4; b++) begin
			src_idle = 1'($urandom_range(0, 1));
			snk_idle = 1'($urandom_range(0, 1));
			style = $urandom_range(0, 2);
			case (style)
				0: fill_block(20, 1'b0);
				1: fill_block(80, 1'b0);
				default: fill_block(97, 1'($urandom_range(0, 1)));
			endcase
			send_block(2'($urandom_range(0, 3)));
		end
	endtask

	task automatic test_output_backpressure();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		hold_cycles = 300;
		fill_block(10, 1'b1);
		send_block(2'($urandom_range(0, 3)));
		snk_idle = 1'b1;
	endtask

	initial begin
		int guard;
		coef_valid <= 1'b0;
		coef_word <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes_and_eob();
		test_long_zero_run();
		test_random_blocks();
		test_output_backpressure();
		coef_valid <= 1'b0;

		guard = 0;
		while (expected_symbols.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_symbols.size() != 0) begin
			$display("%0t: missing symbol words, expected %0d more, actual 0",
				$time, expected_symbols.size());
			mismatches++;
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/dcac_rlc_pkg.sv
hw/rtl/dcac_rlc_front.sv
hw/rtl/dcac_rlc_queue.sv
hw/rtl/dcac_rlc_back.sv
hw/rtl/dc_ac_run_length_coder_core.sv
tb/dc_ac_run_length_coder_core_tb.sv
